FILE: hw/rtl/hsc_pkg.sv
// types, constants and the plane function shared by the segment clipper
`default_nettype none

package hsc_pkg;

    localparam int COORD_W         = 32;
    localparam int T_FRAC_BITS     = 30;
    localparam int Q_W             = T_FRAC_BITS + 1;
    localparam int F_W             = COORD_W + 2;
    localparam int MAG_W           = COORD_W + 1;
    localparam int DEN_W           = MAG_W + 1;
    localparam int REM_W           = DEN_W + 1;
    localparam int PROD_W          = MAG_W + T_FRAC_BITS;
    localparam int SUM_W           = COORD_W + 3;
    localparam int DIV_STEPS       = Q_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int NUM_PLANES      = 6;

    localparam logic [2:0] PLANE_XP   = 3'd0;
    localparam logic [2:0] PLANE_XN   = 3'd1;
    localparam logic [2:0] PLANE_YP   = 3'd2;
    localparam logic [2:0] PLANE_YN   = 3'd3;
    localparam logic [2:0] PLANE_NEAR = 3'd4;
    localparam logic [2:0] PLANE_FAR  = 3'd5;

    localparam logic [2:0] PLANE_SEQ [NUM_PLANES] =
        '{PLANE_XP, PLANE_XN, PLANE_YP, PLANE_YN, PLANE_NEAR, PLANE_FAR};

    typedef struct packed {
        logic                          rejected;
        logic [3:0][COORD_W-1:0]       b;
        logic [3:0][COORD_W-1:0]       a;
    } hsc_seg_t;

    // signed distance outside the plane, positive means outside
    function automatic logic signed [F_W-1:0] plane_value(
        input logic [2:0]         plane,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z,
        input logic [COORD_W-1:0] w,
        input logic               zero_near
    );
        logic signed [F_W-1:0] sx;
        logic signed [F_W-1:0] sy;
        logic signed [F_W-1:0] sz;
        logic signed [F_W-1:0] sw;
        logic signed [F_W-1:0] f;
        sx = $signed({{2{x[COORD_W-1]}}, x});
        sy = $signed({{2{y[COORD_W-1]}}, y});
        sz = $signed({{2{z[COORD_W-1]}}, z});
        sw = $signed({{2{w[COORD_W-1]}}, w});
        case (plane)
            PLANE_XP:   f = sx - sw;
            PLANE_XN:   f = -(sx + sw);
            PLANE_YP:   f = sy - sw;
            PLANE_YN:   f = -(sy + sw);
            PLANE_NEAR: f = zero_near ? -sz : -(sz + sw);
            PLANE_FAR:  f = sz - sw;
            default:    f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hsc_plane.sv
// pipelined clip of one segment against one plane
`default_nettype none

module hsc_plane #(
    parameter logic [2:0] PLANE = hsc_pkg::PLANE_XP
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             zero_near,
    input  wire logic             in_valid,
    input  wire hsc_pkg::hsc_seg_t in_seg,
    output logic                  out_valid,
    output hsc_pkg::hsc_seg_t     out_seg
);
    import hsc_pkg::*;

    typedef struct packed {
        hsc_seg_t                  seg;
        logic                      active;
        logic                      move_a;
        logic [DEN_W-1:0]          den;
        logic [REM_W-1:0]          rem;
        logic [Q_W-1:0]            quo;
        logic [3:0][MAG_W-1:0]     mag_d;
        logic [3:0]                neg_d;
    } div_t;

    typedef struct packed {
        hsc_seg_t                  seg;
        logic                      active;
        logic                      move_a;
        logic [3:0][PROD_W-1:0]    prod;
        logic [3:0]                neg_d;
    } mul_t;

    // plane values
    logic                   pv_valid_reg;
    hsc_seg_t               pv_seg_reg;
    logic signed [F_W-1:0]  pv_fa_reg;
    logic signed [F_W-1:0]  pv_fb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pv_seg_reg <= in_seg;
            pv_fa_reg  <= plane_value(PLANE, in_seg.a[0], in_seg.a[1], in_seg.a[2],
                                      in_seg.a[3], zero_near);
            pv_fb_reg  <= plane_value(PLANE, in_seg.b[0], in_seg.b[1], in_seg.b[2],
                                      in_seg.b[3], zero_near);
        end
    end

    // classify, magnitudes, divider setup
    div_t div_reg       [0:DIV_STAGES];
    logic div_valid_reg [0:DIV_STAGES];
    div_t div_next0;

    always_comb
    begin
        logic              out_a;
        logic              out_b;
        logic [MAG_W-1:0]  mag_a;
        logic [MAG_W-1:0]  mag_b;
        logic signed [MAG_W-1:0] d;
        out_a = (pv_fa_reg > 0);
        out_b = (pv_fb_reg > 0);
        mag_a = pv_fa_reg[F_W-1] ? MAG_W'(-pv_fa_reg) : MAG_W'(pv_fa_reg);
        mag_b = pv_fb_reg[F_W-1] ? MAG_W'(-pv_fb_reg) : MAG_W'(pv_fb_reg);
        div_next0              = '0;
        div_next0.seg          = pv_seg_reg;
        div_next0.seg.rejected = pv_seg_reg.rejected | (out_a & out_b);
        div_next0.active       = out_a ^ out_b;
        div_next0.move_a       = out_a;
        div_next0.den          = DEN_W'(mag_a) + DEN_W'(mag_b);
        div_next0.rem          = REM_W'(mag_a);
        div_next0.quo          = '0;
        for (int i = 0; i < 4; i++)
        begin
            d = $signed({pv_seg_reg.b[i][COORD_W-1], pv_seg_reg.b[i]})
              - $signed({pv_seg_reg.a[i][COORD_W-1], pv_seg_reg.a[i]});
            div_next0.mag_d[i] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
            div_next0.neg_d[i] = d[MAG_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            div_valid_reg[0] <= pv_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= div_next0;
        end
    end

    // restoring divider, two quotient bits per stage
    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_div
        div_t div_next;

        always_comb
        begin
            int j;
            div_next = div_reg[s-1];
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                j = (s - 1) * STEPS_PER_STAGE + k;
                if (j < DIV_STEPS)
                begin
                    if (j != 0)
                    begin
                        div_next.rem = {div_next.rem[REM_W-2:0], 1'b0};
                    end
                    if (div_next.rem >= REM_W'(div_next.den))
                    begin
                        div_next.rem = div_next.rem - REM_W'(div_next.den);
                        div_next.quo[Q_W-1-j] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                div_valid_reg[s] <= div_valid_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[s] <= div_next;
            end
        end
    end

    // offset products
    logic mul_valid_reg;
    mul_t mul_reg;
    mul_t mul_next;

    always_comb
    begin
        mul_next.seg    = div_reg[DIV_STAGES].seg;
        mul_next.active = div_reg[DIV_STAGES].active;
        mul_next.move_a = div_reg[DIV_STAGES].move_a;
        mul_next.neg_d  = div_reg[DIV_STAGES].neg_d;
        for (int i = 0; i < 4; i++)
        begin
            mul_next.prod[i] = PROD_W'(div_reg[DIV_STAGES].mag_d[i])
                             * PROD_W'(div_reg[DIV_STAGES].quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= div_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
        end
    end

    // round, add, saturate, replace the outside end
    logic     out_valid_reg;
    hsc_seg_t out_seg_reg;
    hsc_seg_t out_seg_next;

    always_comb
    begin
        logic [PROD_W-1:0]        rnd;
        logic [MAG_W-1:0]         mag_r;
        logic signed [SUM_W-1:0]  off;
        logic signed [SUM_W-1:0]  sum;
        logic [COORD_W-1:0]       cross_pt;
        out_seg_next = mul_reg.seg;
        for (int i = 0; i < 4; i++)
        begin
            rnd   = mul_reg.prod[i] + (PROD_W'(1) << (T_FRAC_BITS - 1));
            mag_r = rnd[PROD_W-1:T_FRAC_BITS];
            off   = mul_reg.neg_d[i] ? -$signed({2'b00, mag_r}) : $signed({2'b00, mag_r});
            sum   = $signed({{3{mul_reg.seg.a[i][COORD_W-1]}}, mul_reg.seg.a[i]}) + off;
            if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1)
            begin
                cross_pt = sum[COORD_W-1:0];
            end
            else if (sum[SUM_W-1])
            begin
                cross_pt = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                cross_pt = {1'b0, {(COORD_W-1){1'b1}}};
            end
            if (mul_reg.active && mul_reg.move_a)
            begin
                out_seg_next.a[i] = cross_pt;
            end
            if (mul_reg.active && !mul_reg.move_a)
            begin
                out_seg_next.b[i] = cross_pt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_seg_reg <= out_seg_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_seg   = out_seg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/homogeneous_segment_clipper_core.sv
// top level of the homogeneous line segment clipper
//
// channel   dir   handshake                 payload
// s_        in    s_tvalid / s_tready       s_tdata: a_x a_y a_z a_w b_x b_y b_z b_w
// m_        out   m_tvalid / m_tready       m_tdata: clip_a_x .. clip_b_w, m_tuser: visible
// cfg_      in    cfg_valid / cfg_ready     cfg_data: depth_zero_to_one
//
// one word accepted per cycle while the output is not stalled
// each plane: plane values, setup, 16 divider stages, multiply, round and select
// the divider at two quotient bits per stage sets the depth
// reset clears all valid bits and the depth mode register
// a stall at the output freezes the whole pipeline; s_tready follows it
`default_nettype none

module homogeneous_segment_clipper_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [255:0] s_tdata,   // a_x a_y a_z a_w b_x b_y b_z b_w
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata,   // clip_a_x clip_a_y clip_a_z clip_a_w clip_b_x .. clip_b_w
    output logic [0:0]        m_tuser,   // visible
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data
);
    import hsc_pkg::*;

    logic     depth_reg;
    logic     en;
    logic     stage_valid [0:NUM_PLANES];
    hsc_seg_t stage_seg   [0:NUM_PLANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            depth_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    assign stage_valid[0]        = s_tvalid && s_tready;
    assign stage_seg[0].rejected = 1'b0;
    assign stage_seg[0].a        = s_tdata[4*COORD_W-1:0];
    assign stage_seg[0].b        = s_tdata[8*COORD_W-1:4*COORD_W];

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        hsc_plane #(
            .PLANE (PLANE_SEQ[p])
        ) u_plane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .zero_near (depth_reg),
            .in_valid  (stage_valid[p]),
            .in_seg    (stage_seg[p]),
            .out_valid (stage_valid[p+1]),
            .out_seg   (stage_seg[p+1])
        );
    end

    assign m_tvalid   = stage_valid[NUM_PLANES];
    assign m_tuser[0] = !stage_seg[NUM_PLANES].rejected;
    assign m_tdata    = stage_seg[NUM_PLANES].rejected ? '0
                      : {stage_seg[NUM_PLANES].b, stage_seg[NUM_PLANES].a};

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("rejected word carries nonzero coordinates");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage_valid[3]))
        else $error("pipeline moved during output stall");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
`endif

endmodule

`default_nettype wire

FILE: sim/hsc_checker.sv
// checker for the segment clipper: watches the streams, predicts and compares results
`timescale 1ns / 1ps

module hsc_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [255:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [255:0] m_tdata,
    input  wire logic [0:0]   m_tuser,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic         cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                seen_count,
    output int                visible_count
);
    import hsc_pkg::*;

    typedef struct {
        logic [255:0] coords;
        logic         vis;
    } clip_result_t;

    clip_result_t clipped_q[$];
    logic         zero_near;

    function automatic logic signed [63:0] sat_coord(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one plane; returns 0 when both ends are outside
    function automatic logic cut_plane(
        inout logic signed [63:0] pa [4],
        inout logic signed [63:0] pb [4],
        input logic signed [63:0] fa,
        input logic signed [63:0] fb
    );
        logic [63:0]        mag_a;
        logic [63:0]        mag_b;
        logic [63:0]        frac;
        logic signed [63:0] d;
        logic [63:0]        mag_d;
        logic [127:0]       prod;
        logic signed [63:0] off;
        logic signed [63:0] cross_pt [4];
        if (fa > 0 && fb > 0)
            return 1'b0;
        if (fa <= 0 && fb <= 0)
            return 1'b1;
        mag_a = fa < 0 ? -fa : fa;
        mag_b = fb < 0 ? -fb : fb;
        frac  = (mag_a << T_FRAC_BITS) / (mag_a + mag_b);
        for (int i = 0; i < 4; i++)
        begin
            d     = pb[i] - pa[i];
            mag_d = d < 0 ? -d : d;
            prod  = (128'(mag_d) * frac + (128'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
            off   = d < 0 ? -$signed(prod[63:0]) : $signed(prod[63:0]);
            cross_pt[i] = sat_coord(pa[i] + off);
        end
        for (int i = 0; i < 4; i++)
        begin
            if (fa > 0)
                pa[i] = cross_pt[i];
            else
                pb[i] = cross_pt[i];
        end
        return 1'b1;
    endfunction

    function automatic clip_result_t clip_segment(input logic [255:0] word, input logic zn);
        logic signed [63:0] pa [4];
        logic signed [63:0] pb [4];
        logic               ok;
        clip_result_t       res;
        for (int i = 0; i < 4; i++)
        begin
            pa[i] = 64'($signed(word[32*i +: 32]));
            pb[i] = 64'($signed(word[128 + 32*i +: 32]));
        end
        ok = 1'b1;
        for (int ax = 0; ax < 2 && ok; ax++)
        begin
            ok = cut_plane(pa, pb, pa[ax] - pa[3], pb[ax] - pb[3]);
            if (ok)
                ok = cut_plane(pa, pb, -(pa[ax] + pa[3]), -(pb[ax] + pb[3]));
        end
        if (ok)
            ok = zn ? cut_plane(pa, pb, -pa[2], -pb[2])
                    : cut_plane(pa, pb, -(pa[2] + pa[3]), -(pb[2] + pb[3]));
        if (ok)
            ok = cut_plane(pa, pb, pa[2] - pa[3], pb[2] - pb[3]);
        res.vis    = ok;
        res.coords = '0;
        if (ok)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res.coords[32*i +: 32]       = pa[i][31:0];
                res.coords[128 + 32*i +: 32] = pb[i][31:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    assign pending_count = clipped_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        clip_result_t exp_res;
        if (!rst_n)
        begin
            zero_near     <= 1'b0;
            fail_count    = 0;
            seen_count    = 0;
            visible_count = 0;
            clipped_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_count++;
                if (clipped_q.size() == 0)
                    report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
                else
                begin
                    exp_res = clipped_q.pop_front();
                    if (exp_res.vis)
                        visible_count++;
                    if (m_tuser[0] !== exp_res.vis)
                        report_mismatch("visible", 32'(m_tuser[0]), 32'(exp_res.vis));
                    for (int i = 0; i < 8; i++)
                        if (m_tdata[32*i +: 32] !== exp_res.coords[32*i +: 32])
                            report_mismatch($sformatf("coord %0d", i),
                                            m_tdata[32*i +: 32], exp_res.coords[32*i +: 32]);
                end
            end
            if (s_tvalid && s_tready)
                clipped_q.push_back(clip_segment(s_tdata, zero_near));
            if (cfg_valid && cfg_ready)
                zero_near <= cfg_data;
        end
    end

endmodule

FILE: sim/homogeneous_segment_clipper_core_tb.sv
// testbench top for the segment clipper: stimulus, stalls and verdict
`timescale 1ns / 1ps

module homogeneous_segment_clipper_core_tb;

    localparam int LATENCY     = 130;
    localparam int STALL_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;
    int           fail_count;
    int           pending_count;
    int           seen_count;
    int           visible_count;
    int           idle_cycles;
    int           sent_count;
    logic         hold_off;

    homogeneous_segment_clipper_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hsc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .seen_count    (seen_count),
        .visible_count (visible_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    // mostly segments near the clip volume with w positive, some wild ones
    function automatic logic [255:0] rand_segment();
        logic [255:0] seg;
        for (int i = 0; i < 8; i++)
            seg[32*i +: 32] = rand_coord();
        if ($urandom_range(0, 3) != 0)
        begin
            seg[96 +: 32]  = 32'($urandom_range(1 << 14, 4 << 16));
            seg[224 +: 32] = 32'($urandom_range(1 << 14, 4 << 16));
        end
        return seg;
    endfunction

    function automatic logic [255:0] make_seg(input int ax, ay, az, aw, bx, by, bz, bw);
        return {32'(bw), 32'(bz), 32'(by), 32'(bx), 32'(aw), 32'(az), 32'(ay), 32'(ax)};
    endfunction

    task automatic send_word(input logic [255:0] seg);
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && left > 0)
            begin
                send_word(rand_segment());
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(negedge clk);
            end
        end
    endtask

    task automatic directed_phase();
        int one;
        one = 1 << 16;
        send_word(make_seg(0, 0, 0, one, one / 2, one / 2, one / 2, one));
        send_word(make_seg(2 * one, 0, 0, one, -2 * one, 0, 0, one));
        send_word(make_seg(0, 3 * one, 0, one, 0, -3 * one, 0, one));
        send_word(make_seg(0, 0, -2 * one, one, 0, 0, 2 * one, one));
        send_word(make_seg(2 * one, 0, 0, one, 3 * one, 0, 0, one));
        send_word(make_seg(one, one, one, one, -one, -one, -one, one));
        send_word(make_seg(0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_seg(one, 0, 0, -one, 0, 0, 0, one));
        send_word({8{32'h7fff_ffff}});
        send_word({8{32'h8000_0000}});
        send_word({{4{32'h8000_0000}}, {4{32'h7fff_ffff}}});
        send_word(make_seg(-2 * one, 0, 0, one, 0, 0, 0, one));
        send_word(make_seg(0, 0, -one / 2, one, 0, 0, one / 2, one));
        send_word({8{32'hffff_ffff}});
        send_word({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
        send_word({8{32'h5555_aaaa}});
        send_word({8{32'haaaa_5555}});
        s_tvalid <= 1'b0;
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (400)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            else if (sent_count < 300)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("** homogeneous_segment_clipper_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        hold_off    = 1'b0;
        sent_count  = 0;
        idle_cycles = 0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_mode(1'b0);
        directed_phase();
        random_phase(200);
        write_mode(1'b1);
        directed_phase();
        hold_off = 1'b1;
        random_phase(250);
        drain();
        random_phase(200);
        write_mode(1'b0);
        random_phase(200);
        drain();
        $display("sent %0d segments under both near-plane modes, %0d results, %0d visible",
                 sent_count, seen_count, visible_count);
        if (fail_count == 0)
            $display("** homogeneous_segment_clipper_core: PASSED **");
        else
            $display("** homogeneous_segment_clipper_core: FAILED **");
        $finish;
    end

endmodule
